// File: hdl/mmlr_pkg.sv
// ----------------------------------------------------------------------------
// mmlr_pkg: shared types and constants
// Types, constants and the reciprocal table of the mono mix resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mmlr_pkg;

    localparam int FRAME_SAMPLES_DEF = 960;
    localparam int MAX_CHANNELS_DEF  = 8;

    localparam int SAMPLE_W = 24;
    localparam int MASK_W   = 8;
    localparam int PCM_W    = 16;
    localparam int LEVEL_W  = 21;
    localparam int CC_W     = 4;
    localparam int STEP_W   = 20;
    localparam int PHASE_W  = 20;
    localparam int FILL_W   = 10;
    localparam int SUM_W    = 27;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int RECIP_SHIFT = 28;

    localparam logic [PHASE_W:0]    ONE_Q16 = 21'd65536;
    localparam logic [SAMPLE_W-1:0] ONE_Q20 = 24'd1048576;
    localparam logic [2:0]          MAX_POINTS = 3'd4;

    localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = 4'd2;
    localparam logic [STEP_W-1:0] RESAMPLE_STEP_RST = 20'd196608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_RESAMPLE_STEP = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        KIND_PCM   = 1'b0,
        KIND_LEVEL = 1'b1
    } t_kind;

    typedef struct packed {
        logic load;
        logic acc;
        logic div1;
        logic div2;
        logic int1;
        logic int2;
        logic emit;
        logic fin;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic acc_done;
        logic go_point;
        logic out_free;
        logic last;
        logic peak_nz;
    } t_status;

    function automatic logic [RECIP_SHIFT:0] recip(input logic [3:0] d);
        logic [RECIP_SHIFT:0] r;
        begin
            case (d)
                4'd1:    r = 29'd268435456;
                4'd2:    r = 29'd134217728;
                4'd3:    r = 29'd89478485;
                4'd4:    r = 29'd67108864;
                4'd5:    r = 29'd53687091;
                4'd6:    r = 29'd44739242;
                4'd7:    r = 29'd38347922;
                4'd8:    r = 29'd33554432;
                default: r = 29'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/mmlr_if.sv
// ----------------------------------------------------------------------------
// mmlr interfaces: frame, result and configuration channels
// Valid/ready channels carrying the payload of each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmlr_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_ch0;
    logic signed [23:0] sample_ch1;
    logic signed [23:0] sample_ch2;
    logic signed [23:0] sample_ch3;
    logic signed [23:0] sample_ch4;
    logic signed [23:0] sample_ch5;
    logic signed [23:0] sample_ch6;
    logic signed [23:0] sample_ch7;
    logic        [7:0]  present_mask;
    logic               batch_last;

    modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    sample_ch4, sample_ch5, sample_ch6, sample_ch7, present_mask,
                    batch_last, input ready);
    modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  sample_ch4, sample_ch5, sample_ch6, sample_ch7, present_mask,
                  batch_last, output ready);
endinterface

interface mmlr_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] pcm_value;
    logic               frame_end;
    logic        [20:0] peak_level;

    modport source (output valid, kind, pcm_value, frame_end, peak_level,
                    input ready);
    modport sink (input valid, kind, pcm_value, frame_end, peak_level,
                  output ready);
endinterface

interface mmlr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mono_mix_linear_resample_pcm16.sv
// ----------------------------------------------------------------------------
// mono_mix_linear_resample_pcm16: mono mix-down and linear resampler
// Mixes multichannel Q4.20 frames to mono and resamples them to PCM16.
// ----------------------------------------------------------------------------
// Frames arrive on i_in, one per transaction; results leave on o_out, PCM
// points first and then a batch level report when one is due. Registers are
// written on i_cfg, which is always ready; the user must write them only while
// the block is idle, as the block itself does not enforce it. A frame is
// accepted only in the idle state. The mix accumulates one channel per cycle
// over the effective channel count n (1 to MAX_CHANNELS), then the reciprocal
// division runs in S_DIV1 and S_DIV2, and S_LOOP decides whether a point is
// due. Each interpolated point passes S_INT1 and S_INT2 in the shared
// interpolator and scaler, then S_EMIT, which loads the output register, and
// then S_LOOP again to decide. S_FIN closes the frame, and S_REP then sends a
// batch report when one is due.
// Results sit in one output register; when the receiver stalls, the block
// holds at the next point or report until that register is taken.
// Synchronous reset clears the history, phase, frame count, batch peak and
// the output register, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_mix_linear_resample_pcm16 #(
    parameter int FRAME_SAMPLES = mmlr_pkg::FRAME_SAMPLES_DEF,
    parameter int MAX_CHANNELS  = mmlr_pkg::MAX_CHANNELS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mmlr_in_if.sink    i_in,
    mmlr_out_if.source o_out,
    mmlr_cfg_if.sink   i_cfg
);
    import mmlr_pkg::*;

    t_cmd    cmd;
    t_status status;

    mmlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mmlr_dp #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

`default_nettype wire

// File: hdl/mmlr_ctrl.sv
// ----------------------------------------------------------------------------
// mmlr_ctrl: sequencing controller
// Steps the datapath through mix, divide, interpolate and report.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  mmlr_pkg::t_status i_status,
    output mmlr_pkg::t_cmd    o_cmd
);
    import mmlr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ACC  = 10'b0000000010,
        S_DIV1 = 10'b0000000100,
        S_DIV2 = 10'b0000001000,
        S_LOOP = 10'b0000010000,
        S_INT1 = 10'b0000100000,
        S_INT2 = 10'b0001000000,
        S_EMIT = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_REP  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.acc_done) begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div1 = 1'b1;
                n_state    = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = S_LOOP;
            end
            S_LOOP: begin
                n_state = i_status.go_point ? S_INT1 : S_FIN;
            end
            S_INT1: begin
                o_cmd.int1 = 1'b1;
                n_state    = S_INT2;
            end
            S_INT2: begin
                o_cmd.int2 = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = (i_status.last && i_status.peak_nz) ? S_REP : S_IDLE;
            end
            S_REP: begin
                if (i_status.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mmlr_dp.sv
// ----------------------------------------------------------------------------
// mmlr_dp: mix and resampling datapath
// Channel accumulator, reciprocal divider, interpolator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlr_dp #(
    parameter int FRAME_SAMPLES = mmlr_pkg::FRAME_SAMPLES_DEF,
    parameter int MAX_CHANNELS  = mmlr_pkg::MAX_CHANNELS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mmlr_in_if.sink           i_in,
    mmlr_out_if.source        o_out,
    mmlr_cfg_if.sink          i_cfg,
    input  mmlr_pkg::t_cmd    i_cmd,
    output mmlr_pkg::t_status o_status
);
    import mmlr_pkg::*;

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CC_W-1:0]   MAXC = CC_W'(MAX_CHANNELS);
    localparam logic [FILL_W:0]   FRAME_N = (FILL_W + 1)'(FRAME_SAMPLES);
    localparam logic [SAMPLE_W:0] PCM_BIAS = 25'd1048575;

    logic [CC_W-1:0]   r_channel_count;
    logic [STEP_W-1:0] r_resample_step;

    logic signed [SAMPLE_W-1:0] r_samp [MAX_CHANNELS];
    logic [MASK_W-1:0]          r_mask;
    logic                       r_last;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              r_last_ch;
    logic signed [SUM_W-1:0]    r_sum;
    logic [3:0]                 r_valid;
    logic [SUM_W-1:0]           r_abs;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_q0;
    logic signed [SAMPLE_W-1:0] r_mono;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       r_have;
    logic [PHASE_W-1:0]         r_phase;
    logic [PHASE_W:0]           r_work;
    logic [2:0]                 r_npts;
    logic [FILL_W-1:0]          r_fill;
    logic [SAMPLE_W-1:0]        r_peak;
    logic signed [40:0]         r_prod;
    logic signed [21:0]         r_m;

    logic                       r_out_valid;
    logic                       r_kind;
    logic signed [PCM_W-1:0]    r_pcm;
    logic                       r_fe;
    logic [LEVEL_W-1:0]         r_level;

    logic signed [SAMPLE_W-1:0] in_samp [8];
    logic [CC_W-1:0]            eff_cc;
    logic [SUM_W-1:0]           abs_sum;
    logic [55:0]                div_prod;
    logic [SUM_W:0]             rem;
    logic [SUM_W-1:0]           quot;
    logic [SAMPLE_W-1:0]        mag;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [41:0]         prod;
    logic signed [41:0]         prod_adj;
    logic signed [25:0]         m_full;
    logic signed [21:0]         m_clamp;
    logic signed [37:0]         scaled;
    logic signed [37:0]         scaled_adj;
    logic [FILL_W:0]            fill_inc;
    logic                       out_free;

    assign in_samp[0] = i_in.sample_ch0;
    assign in_samp[1] = i_in.sample_ch1;
    assign in_samp[2] = i_in.sample_ch2;
    assign in_samp[3] = i_in.sample_ch3;
    assign in_samp[4] = i_in.sample_ch4;
    assign in_samp[5] = i_in.sample_ch5;
    assign in_samp[6] = i_in.sample_ch6;
    assign in_samp[7] = i_in.sample_ch7;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_channel_count == '0) begin
            eff_cc = CC_W'(1);
        end else if (r_channel_count > MAXC) begin
            eff_cc = MAXC;
        end else begin
            eff_cc = r_channel_count;
        end
    end

    assign abs_sum  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign div_prod = 56'(abs_sum) * 56'(recip(r_valid));
    assign rem      = (SUM_W + 1)'(r_abs) - (SUM_W + 1)'(r_q0 * SUM_W'(r_valid));
    always_comb begin
        if (r_valid == '0) begin
            quot = '0;
        end else if (rem >= (SUM_W + 1)'(r_valid)) begin
            quot = r_q0 + SUM_W'(1);
        end else begin
            quot = r_q0;
        end
    end
    assign mag = quot[SAMPLE_W-1:0];

    assign diff     = (SAMPLE_W + 1)'(r_mono) - (SAMPLE_W + 1)'(r_prev);
    assign prod     = 42'(diff) * $signed({26'd0, r_work[15:0]});
    assign prod_adj = 42'(r_prod) + (r_prod[40] ? 42'sd65535 : 42'sd0);
    assign m_full   = 26'(r_prev) + 26'(prod_adj >>> 16);
    always_comb begin
        if (m_full > 26'sd1048576) begin
            m_clamp = 22'sd1048576;
        end else if (m_full < -26'sd1048576) begin
            m_clamp = -22'sd1048576;
        end else begin
            m_clamp = 22'(m_full);
        end
    end
    assign scaled     = 38'(r_m) * 38'sd32767;
    assign scaled_adj = scaled + (scaled[37] ? 38'(PCM_BIAS) : 38'sd0);
    assign fill_inc   = (FILL_W + 1)'(r_fill) + (FILL_W + 1)'(1);
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_status.acc_done = (r_cnt == r_last_ch);
    assign o_status.go_point = r_have && (r_work < ONE_Q16) && (r_npts < MAX_POINTS);
    assign o_status.out_free = out_free;
    assign o_status.last     = r_last;
    assign o_status.peak_nz  = (r_peak != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_samp[k] <= in_samp[k];
            end
            r_mask    <= i_in.present_mask;
            r_last    <= i_in.batch_last;
            r_cnt     <= '0;
            r_last_ch <= CW'(eff_cc - CC_W'(1));
            r_sum     <= '0;
            r_valid   <= '0;
        end
        if (i_cmd.acc) begin
            if (r_mask[r_cnt]) begin
                r_sum   <= r_sum + SUM_W'(r_samp[r_cnt]);
                r_valid <= r_valid + 4'd1;
            end
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.div1) begin
            r_abs <= abs_sum;
            r_neg <= r_sum[SUM_W-1];
            r_q0  <= div_prod[RECIP_SHIFT +: SUM_W];
        end
        if (i_cmd.div2) begin
            r_mono <= r_neg ? -SAMPLE_W'(quot) : SAMPLE_W'(quot);
            r_npts <= '0;
            r_work <= {1'b0, r_phase};
        end
        if (i_cmd.int1) begin
            r_prod <= 41'(prod);
        end
        if (i_cmd.int2) begin
            r_m <= m_clamp;
        end
        if (i_cmd.emit) begin
            r_work <= r_work + (PHASE_W + 1)'(r_resample_step);
            r_npts <= r_npts + 3'd1;
        end
        if (i_cmd.emit || i_cmd.report) begin
            r_kind  <= i_cmd.report ? KIND_LEVEL : KIND_PCM;
            r_pcm   <= i_cmd.report ? '0 : PCM_W'(scaled_adj >>> 20);
            r_fe    <= i_cmd.report ? 1'b0 : (fill_inc >= FRAME_N);
            r_level <= !i_cmd.report ? '0 :
                       (r_peak > ONE_Q20) ? LEVEL_W'(ONE_Q20) : LEVEL_W'(r_peak);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RST;
            r_resample_step <= RESAMPLE_STEP_RST;
            r_prev          <= '0;
            r_have          <= 1'b0;
            r_phase         <= '0;
            r_fill          <= '0;
            r_peak          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[CC_W-1:0];
                    CFG_RESAMPLE_STEP: r_resample_step <= i_cfg.data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.div2 && (mag > r_peak)) begin
                r_peak <= mag;
            end
            if (i_cmd.emit) begin
                r_fill <= (fill_inc >= FRAME_N) ? '0 : FILL_W'(fill_inc);
            end
            if (i_cmd.fin) begin
                if (r_have) begin
                    r_phase <= (r_work < ONE_Q16) ? '0 : PHASE_W'(r_work - ONE_Q16);
                end
                r_prev <= r_mono;
                r_have <= 1'b1;
            end
            if (i_cmd.report) begin
                r_peak <= '0;
            end
            if (i_cmd.emit || i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_kind;
    assign o_out.pcm_value  = r_pcm;
    assign o_out.frame_end  = r_fe;
    assign o_out.peak_level = r_level;

endmodule

`default_nettype wire

// File: hdl/mmlr_checker.sv
// ----------------------------------------------------------------------------
// mmlr_checker: port assertions
// Checks result channel behaviour seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mmlr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_kind,
    input wire [15:0] i_pcm_value,
    input wire        i_frame_end,
    input wire [20:0] i_peak_level
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result dropped while stalled.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind |-> i_pcm_value == 16'd0 && !i_frame_end)
        else $error("Level report carries sample fields.");

    a_report_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind |-> i_peak_level != 21'd0 && i_peak_level <= 21'd1048576)
        else $error("Level report out of range.");

    a_pcm_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_kind |-> i_peak_level == 21'd0 && i_pcm_value != 16'h8000)
        else $error("Sample result malformed.");

endmodule

bind mono_mix_linear_resample_pcm16 mmlr_checker u_mmlr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.kind),
    .i_pcm_value  (o_out.pcm_value),
    .i_frame_end  (o_out.frame_end),
    .i_peak_level (o_out.peak_level)
);

`default_nettype wire
